/* sv/psc_pkg.sv */
// Shared constants, mode codes and arctangent table for the phasor sequence block.
package psc_pkg;

    // mode codes
    localparam logic [2:0] MODE_UBC = 3'd0;
    localparam logic [2:0] MODE_UCA = 3'd1;
    localparam logic [2:0] MODE_UAB = 3'd2;
    localparam logic [2:0] MODE_ZERO = 3'd3;
    localparam logic [2:0] MODE_NEG = 3'd4;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN = 24;

    // angles in 1/64 degree
    localparam logic signed [16:0] FULL_TURN = 17'sd23040;
    localparam logic signed [16:0] THREE_QUARTER = 17'sd17280;
    localparam logic signed [16:0] HALF_TURN = 17'sd11520;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
    localparam logic signed [16:0] THIRD_TURN = 17'sd7680;

    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam logic [24:0] MAG_LIMIT = 25'h1FFFFFF;
    localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

    localparam int SQ_W = 62;     // width of x^2 + y^2
    localparam int ROOT_W = 31;   // width of its square root

    // atan(2^-i) in 2^-20 degree
    localparam logic signed [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058, 32'sd1876857, 32'sd938658, 32'sd469357,
        32'sd234682, 32'sd117342, 32'sd58671, 32'sd29335,
        32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
        32'sd917, 32'sd458, 32'sd229, 32'sd115,
        32'sd57, 32'sd29, 32'sd14, 32'sd7
    };

endpackage

/* sv/phasor_sequence_component.sv */
// Top level: line voltage or sequence component, magnitude and angle, from three phasors.
//
// The block takes one word per clock while the output is not held and returns one word per
// item, in order. Each input word carries three phasors (magnitude Q16.8, angle in 1/64
// degree) and a mode in tuser: 0 Ub-Uc, 1 Uc-Ua, 2 Ua-Ub, 3 zero sequence, 4 negative
// sequence. Each phasor goes through a CORDIC rotation of CORDIC_STAGES stages, the chosen
// combination is formed, its magnitude comes from a 31-stage square root and its angle from
// a CORDIC vectoring pass run in parallel. Throughput is one item per cycle while the output
// is not held. The whole pipeline advances whenever the output register is empty or being
// taken, so a held output freezes every stage and nothing is lost or repeated. Modes 5 to 7
// return zero magnitude and angle with mode_error set in tuser. A zero vector reports angle 0.
module phasor_sequence_component import psc_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // mag_a[23:0], ang_a[39:24], mag_b[63:40], ang_b[79:64], mag_c[103:80], ang_c[119:104]
    input  logic [119:0] i_s_tdata,
    // mode[2:0]
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // result_mag[24:0], result_ang[39:25]
    output logic [39:0]  o_m_tdata,
    // mode_error[0]
    output logic         o_m_tuser
);

    localparam int ROT_LAT = CORDIC_STAGES + 3;
    localparam int TOTAL   = ROT_LAT + 36;
    localparam int ANG_DLY = 25 - CORDIC_STAGES;

    // pipeline advance
    logic ce;
    logic acc;

    logic       r_vld [1:TOTAL];
    logic [2:0] r_md  [1:TOTAL];

    logic signed [16:0] w_ang_a, w_ang_b, w_ang_c;
    logic signed [31:0] w_xa, w_ya, w_xb, w_yb, w_xc, w_yc;
    logic signed [31:0] w_cx, w_cy;

    logic signed [31:0] r_cx, r_cy;
    logic [SQ_W-1:0]    r_sqx, r_sqy, r_sum;
    logic [ROOT_W-1:0]  w_root;
    logic [31:0]        w_t48;
    logic [63:0]        r_scl;
    logic               r_div3;
    logic [63:0]        w_mag;

    logic signed [31:0] w_px, w_py;
    logic               w_neg;
    logic signed [44:0] r_nx [0:6];
    logic signed [44:0] r_ny [0:6];
    logic [40:0]        r_nm [0:6];
    logic signed [31:0] r_nz [0:6];
    logic               r_nzero [0:6];

    logic signed [44:0] r_vx [0:CORDIC_STAGES];
    logic signed [44:0] r_vy [0:CORDIC_STAGES];
    logic signed [31:0] r_vz [0:CORDIC_STAGES];
    logic               r_vzero [0:CORDIC_STAGES];

    logic signed [31:0] w_q;
    logic [14:0]        r_ang;
    logic [14:0]        r_adl [0:ANG_DLY-1];

    logic [24:0] r_omag;
    logic [14:0] r_oang;
    logic        r_oerr;

    assign ce  = !r_vld[TOTAL] || i_m_tready;
    assign acc = i_s_tvalid && ce;
    assign o_s_tready = ce;

    // valid and mode travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= TOTAL; i++) r_vld[i] <= 1'b0;
        end else if (ce) begin
            r_vld[1] <= acc;
            for (int i = 2; i <= TOTAL; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_md[1] <= i_s_tuser;
            for (int i = 2; i <= TOTAL; i++) r_md[i] <= r_md[i-1];
        end
    end

    // negative sequence: turn B by -120 and C by +120 degrees
    always_comb begin
        w_ang_a = 17'(signed'(i_s_tdata[39:24]));
        w_ang_b = 17'(signed'(i_s_tdata[79:64]));
        w_ang_c = 17'(signed'(i_s_tdata[119:104]));
        if (i_s_tuser == MODE_NEG) begin
            w_ang_b = w_ang_b - THIRD_TURN;
            w_ang_c = w_ang_c + THIRD_TURN;
        end
    end

    psc_rotate #(.CORDIC_STAGES(CORDIC_STAGES)) u_rot_a (
        .i_clk(i_clk), .i_ce(ce), .i_mag(i_s_tdata[23:0]), .i_ang(w_ang_a),
        .o_x(w_xa), .o_y(w_ya)
    );
    psc_rotate #(.CORDIC_STAGES(CORDIC_STAGES)) u_rot_b (
        .i_clk(i_clk), .i_ce(ce), .i_mag(i_s_tdata[63:40]), .i_ang(w_ang_b),
        .o_x(w_xb), .o_y(w_yb)
    );
    psc_rotate #(.CORDIC_STAGES(CORDIC_STAGES)) u_rot_c (
        .i_clk(i_clk), .i_ce(ce), .i_mag(i_s_tdata[103:80]), .i_ang(w_ang_c),
        .o_x(w_xc), .o_y(w_yc)
    );

    // form the selected combination
    always_comb begin
        unique case (r_md[ROT_LAT])
            MODE_UBC: begin w_cx = w_xb - w_xc; w_cy = w_yb - w_yc; end
            MODE_UCA: begin w_cx = w_xc - w_xa; w_cy = w_yc - w_ya; end
            MODE_UAB: begin w_cx = w_xa - w_xb; w_cy = w_ya - w_yb; end
            default:  begin w_cx = w_xa + w_xb + w_xc; w_cy = w_ya + w_yb + w_yc; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cx <= w_cx;
            r_cy <= w_cy;
        end
    end

    // magnitude: square, sum, root
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sqx <= SQ_W'(ROOT_W'(r_cx[31] ? -r_cx : r_cx))
                   * SQ_W'(ROOT_W'(r_cx[31] ? -r_cx : r_cx));
            r_sqy <= SQ_W'(ROOT_W'(r_cy[31] ? -r_cy : r_cy))
                   * SQ_W'(ROOT_W'(r_cy[31] ? -r_cy : r_cy));
            r_sum <= r_sqx + r_sqy;
        end
    end

    psc_isqrt u_sqrt (
        .i_clk(i_clk), .i_ce(ce), .i_val(r_sum), .o_root(w_root)
    );

    // line quantities scale by 1/16, sequence quantities by 1/48 (1/16 then 1/3)
    assign w_t48 = (32'(w_root) + 32'd24) >> 4;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (r_md[ROT_LAT+34] <= MODE_UAB) begin
                r_scl  <= 64'((32'(w_root) + 32'd8) >> 4);
                r_div3 <= 1'b0;
            end else begin
                r_scl  <= 64'(w_t48[27:0]) * 64'(RECIP3);
                r_div3 <= 1'b1;
            end
        end
    end

    assign w_mag = r_div3 ? (r_scl >> 33) : r_scl;

    // angle: move to the right half plane
    assign w_neg = r_cx[31];
    assign w_px  = w_neg ? -r_cx : r_cx;
    assign w_py  = w_neg ? -r_cy : r_cy;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_nx[0]    <= 45'(w_px);
            r_ny[0]    <= 45'(w_py);
            r_nm[0]    <= 41'(w_px[30:0] | (w_py[31] ? 31'(-w_py) : w_py[30:0]));
            r_nz[0]    <= w_neg ? (32'sd180 <<< 20) : 32'sd0;
            r_nzero[0] <= (r_cx == 0) && (r_cy == 0);
        end
    end

    // normalize until the larger component reaches 2^40
    for (genvar q = 0; q < 6; q++) begin : g_norm
        localparam int K = 32 >> q;
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_nz[q+1]    <= r_nz[q];
                r_nzero[q+1] <= r_nzero[q];
                if (r_nm[q] < (41'(1) << (41 - K))) begin
                    r_nx[q+1] <= r_nx[q] <<< K;
                    r_ny[q+1] <= r_ny[q] <<< K;
                    r_nm[q+1] <= r_nm[q] << K;
                end else begin
                    r_nx[q+1] <= r_nx[q];
                    r_ny[q+1] <= r_ny[q];
                    r_nm[q+1] <= r_nm[q];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_vx[0]    <= r_nx[6];
            r_vy[0]    <= r_ny[6];
            r_vz[0]    <= r_nz[6];
            r_vzero[0] <= r_nzero[6];
        end
    end

    // vectoring: drive y to zero, accumulate the angle
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_vzero[k+1] <= r_vzero[k];
                if (r_vy[k] > 0) begin
                    r_vx[k+1] <= r_vx[k] + (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] - (r_vx[k] >>> k);
                    r_vz[k+1] <= r_vz[k] + ATAN_TAB[k];
                end else begin
                    r_vx[k+1] <= r_vx[k] - (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] + (r_vx[k] >>> k);
                    r_vz[k+1] <= r_vz[k] - ATAN_TAB[k];
                end
            end
        end
    end

    // round to 1/64 degree and wrap into one turn
    always_comb begin
        w_q = (r_vz[CORDIC_STAGES] + 32'sd8192) >>> 14;
        if (w_q < 0) w_q = w_q + 32'(FULL_TURN);
        if (w_q >= 32'(FULL_TURN)) w_q = w_q - 32'(FULL_TURN);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ang <= r_vzero[CORDIC_STAGES] ? 15'd0 : w_q[14:0];
            r_adl[0] <= r_ang;
            for (int i = 1; i < ANG_DLY; i++) r_adl[i] <= r_adl[i-1];
        end
    end

    // output register; zero everything on a bad mode
    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (r_md[TOTAL-1] > MODE_NEG) begin
                r_omag <= '0;
                r_oang <= '0;
                r_oerr <= 1'b1;
            end else begin
                r_omag <= (w_mag > 64'(MAG_LIMIT)) ? MAG_LIMIT : w_mag[24:0];
                r_oang <= r_adl[ANG_DLY-1];
                r_oerr <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_vld[TOTAL];
    assign o_m_tdata  = {r_oang, r_omag};
    assign o_m_tuser  = r_oerr;

endmodule

/* sv/psc_rotate.sv */
// Polar to rectangular conversion of one phasor by a pipelined CORDIC rotation.
module psc_rotate import psc_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_ce,
    input  logic [23:0]        i_mag,
    input  logic signed [16:0] i_ang,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y
);

    logic signed [16:0] w_wrap;
    logic signed [16:0] w_fold;
    logic               w_flip;
    logic [53:0]        w_prod;

    logic signed [16:0] r_fold;
    logic [23:0]        r_mag;
    logic               r_flip0;
    logic               r_flip [0:CORDIC_STAGES];
    logic signed [31:0] r_x [0:CORDIC_STAGES];
    logic signed [31:0] r_y [0:CORDIC_STAGES];
    logic signed [31:0] r_z [0:CORDIC_STAGES];
    logic signed [31:0] r_ox;
    logic signed [31:0] r_oy;

    // reduce into one turn, then fold into -90..+90 degrees
    always_comb begin
        w_wrap = i_ang;
        if (w_wrap < 0) w_wrap = w_wrap + FULL_TURN;
        if (w_wrap < 0) w_wrap = w_wrap + FULL_TURN;
        if (w_wrap >= FULL_TURN) w_wrap = w_wrap - FULL_TURN;
        w_fold = w_wrap;
        w_flip = 1'b0;
        if (w_wrap > QUARTER_TURN && w_wrap < THREE_QUARTER) begin
            w_fold = w_wrap - HALF_TURN;
            w_flip = 1'b1;
        end else if (w_wrap >= THREE_QUARTER) begin
            w_fold = w_wrap - FULL_TURN;
        end
    end

    assign w_prod = 54'(r_mag) * 54'(GAIN_Q30) + (54'(1) << 25);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_fold  <= w_fold;
            r_mag   <= i_mag;
            r_flip0 <= w_flip;
            r_x[0]  <= $signed({4'b0, w_prod[53:26]});
            r_y[0]  <= '0;
            r_z[0]  <= 32'(r_fold) <<< 14;
            r_flip[0] <= r_flip0;
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_flip[k+1] <= r_flip[k];
                if (!r_z[k][31]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ATAN_TAB[k];
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ATAN_TAB[k];
                end
            end
        end
    end

    // undo the half-turn fold
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ox <= r_flip[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];
            r_oy <= r_flip[CORDIC_STAGES] ? -r_y[CORDIC_STAGES] : r_y[CORDIC_STAGES];
        end
    end

    assign o_x = r_ox;
    assign o_y = r_oy;

endmodule

/* sv/psc_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module psc_isqrt import psc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_ce,
    input  logic [SQ_W-1:0]   i_val,
    output logic [ROOT_W-1:0] o_root
);

    logic [ROOT_W-1:0] s_root [0:ROOT_W];
    logic [SQ_W-1:0]   s_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [SQ_W-1:0]   r_rem  [0:ROOT_W-1];

    assign s_root[0] = '0;
    assign s_rem[0]  = i_val;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
        localparam int B = ROOT_W - 1 - j;
        logic [SQ_W-1:0] w_trial;

        // (2*root + 2^B) * 2^B, root holds only bits above B
        assign w_trial = (SQ_W'(s_root[j]) << (B + 1)) | (SQ_W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (s_rem[j] >= w_trial) begin
                    r_rem[j]  <= s_rem[j] - w_trial;
                    r_root[j] <= s_root[j] | (ROOT_W'(1) << B);
                end else begin
                    r_rem[j]  <= s_rem[j];
                    r_root[j] <= s_root[j];
                end
            end
        end

        assign s_root[j+1] = r_root[j];
        assign s_rem[j+1]  = r_rem[j];
    end

    assign o_root = s_root[ROOT_W];

endmodule

/* sv/psc_checker.sv */
// Port-level checks for the phasor sequence block, bound to the top level.
module psc_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tuser
);

    // a bad mode carries no magnitude or angle
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 40'd0))
        else $error("mode error word with nonzero payload");

    // angle stays inside one turn
    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[39:25] < 15'd23040))
        else $error("angle out of range");

    // an empty output never blocks the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                          && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind phasor_sequence_component psc_port_checks u_psc_port_checks (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata),
    .o_m_tuser(o_m_tuser)
);

/* tb/psc_checker.sv */
`timescale 1ns / 100ps
// Checker for the phasor sequence block: predicts each result word and compares it.
module psc_checker import psc_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [119:0] i_s_tdata,
    input  logic [2:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [39:0]  i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending,
    output int           o_checked
);

    typedef struct packed {
        logic [24:0] mag;
        logic [14:0] ang;
        logic        mode_err;
    } seq_result_t;

    seq_result_t result_fifo [$];

    function automatic longint wrap_deg64(input longint a);
        longint r;
        r = a % 23040;
        if (r < 0) r += 23040;
        return r;
    endfunction

    // rotate (mag, 0) by the phase angle; x and y in Q.12
    function automatic void phasor_to_rect(input logic [23:0] mag, input longint ang,
                                           output longint xo, output longint yo);
        longint a, x, y, z, dx, dy;
        logic flip;
        a = wrap_deg64(ang);
        flip = 1'b0;
        if (a > 5760 && a < 17280) begin
            a -= 11520;
            flip = 1'b1;
        end else if (a >= 17280) begin
            a -= 23040;
        end
        z = a * 16384;
        x = longint'((longint'(mag) * longint'(GAIN_Q30) + (longint'(1) << 25)) >>> 26);
        y = 0;
        for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        xo = flip ? -x : x;
        yo = flip ? -y : y;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint vector_deg(input longint xi, input longint yi);
        longint x, y, z, ax, ay, dx, dy, q;
        x = xi; y = yi; z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x; y = -y;
            z = longint'(180) * 1048576;
        end
        ax = x;
        ay = (y < 0) ? -y : y;
        // normalize so the vectoring pass keeps its resolution
        while (ax < (longint'(1) << 40) && ay < (longint'(1) << 40)) begin
            x *= 2; y *= 2; ax *= 2; ay *= 2;
        end
        for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        q = (z + 8192) >>> 14;
        while (q < 0) q += 23040;
        while (q >= 23040) q -= 23040;
        return q;
    endfunction

    function automatic seq_result_t predict_sequence(input logic [2:0] mode,
                                                      input logic [119:0] d);
        seq_result_t res;
        longint aa, ab, ac, xa, ya, xb, yb, xc, yc, x, y;
        longint unsigned ux, uy, r, m;
        res = '0;
        if (mode > MODE_NEG) begin
            res.mode_err = 1'b1;
            return res;
        end
        aa = longint'($signed(d[39:24]));
        ab = longint'($signed(d[79:64]));
        ac = longint'($signed(d[119:104]));
        if (mode == MODE_NEG) begin
            ab -= 7680;
            ac += 7680;
        end
        phasor_to_rect(d[23:0], aa, xa, ya);
        phasor_to_rect(d[63:40], ab, xb, yb);
        phasor_to_rect(d[103:80], ac, xc, yc);
        case (mode)
            MODE_UBC: begin x = xb - xc; y = yb - yc; end
            MODE_UCA: begin x = xc - xa; y = yc - ya; end
            MODE_UAB: begin x = xa - xb; y = ya - yb; end
            default:  begin x = xa + xb + xc; y = ya + yb + yc; end
        endcase
        ux = (x < 0) ? -x : x;
        uy = (y < 0) ? -y : y;
        r = root_floor(ux * ux + uy * uy);
        if (mode <= MODE_UAB) m = (r + 8) >> 4;
        else m = (r + 24) / 48;
        if (m > MAG_LIMIT) m = MAG_LIMIT;
        res.mag = m[24:0];
        res.ang = 15'(vector_deg(x, y));
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        seq_result_t want;
        if (!i_rst_n) begin
            o_errors = 0;
            o_checked = 0;
            o_pending = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                result_fifo.push_back(predict_sequence(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (result_fifo.size() == 0) begin
                    report("unexpected word", i_m_tdata, 0);
                end else begin
                    want = result_fifo.pop_front();
                    if (i_m_tdata[24:0] !== want.mag)
                        report("result_mag", i_m_tdata[24:0], want.mag);
                    if (i_m_tdata[39:25] !== want.ang)
                        report("result_ang", i_m_tdata[39:25], want.ang);
                    if (i_m_tuser !== want.mode_err)
                        report("mode_error", i_m_tuser, want.mode_err);
                end
                o_checked++;
            end
            o_pending = result_fifo.size();
        end
    end

endmodule

/* tb/phasor_sequence_component_tb.sv */
`timescale 1ns / 100ps
// Testbench top: drives phasor words with random gaps and stalls, and gives the verdict.
module phasor_sequence_component_tb import psc_pkg::*;;

    localparam int LATENCY = CORDIC_STAGES_DEF + 39;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 600;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // mag_a[23:0], ang_a[39:24], mag_b[63:40], ang_b[79:64], mag_c[103:80], ang_c[119:104]
    logic [119:0] i_s_tdata = '0;
    // mode[2:0]
    logic [2:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // result_mag[24:0], result_ang[39:25]
    logic [39:0]  o_m_tdata;
    // mode_error[0]
    logic         o_m_tuser;

    int errors, pending, checked;
    int cycles = 0;
    int words_sent = 0;
    int bad_mode_words = 0;
    int stall_left = 0;
    logic steady_sink = 1'b0;

    always #1 i_clk = ~i_clk;

    phasor_sequence_component uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    psc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    // Hold the run to a hard cycle budget.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: stall at random, with stretches of steady acceptance.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) steady_sink = ~steady_sink;
            if (steady_sink) begin
                i_m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                stall_left = gap_len();
                i_m_tready <= (stall_left == 0);
            end
        end
    end

    function automatic logic [119:0] pack_phasors(
        input logic [23:0] ma, input logic [15:0] aa,
        input logic [23:0] mb, input logic [15:0] ab,
        input logic [23:0] mc, input logic [15:0] ac);
        return {ac, mc, ab, mb, aa, ma};
    endfunction

    function automatic logic [23:0] rand_mag();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, 255));
            1: return 24'hFFFFFF - 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly -23040 to 23039 (one turn either way), sometimes any 16-bit value.
    function automatic logic [15:0] rand_ang();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 46079)) - 23040);
    endfunction

    // Present one word and hold it until taken; drop valid only when a gap follows.
    task automatic send_word(input logic [2:0] mode, input logic [119:0] data,
                             input bit no_gap);
        int gap;
        i_s_tuser = mode;
        i_s_tdata = data;
        i_s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        words_sent++;
        if (mode > MODE_NEG) bad_mode_words++;
        @(negedge i_clk);
        gap = no_gap ? 0 : gap_len();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin
        logic [23:0] m;
        logic [15:0] base;
        logic [2:0] mode;
        int burst;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every mode, including the invalid ones.
        for (int k = 0; k < 8; k++)
            send_word(3'(k), pack_phasors(24'd25600, 16'd0, 24'd25600, -16'sd7680,
                                          24'd25600, 16'sd7680), 1'b0);
        // magnitude extremes and angle boundaries
        send_word(MODE_UBC, pack_phasors(24'hFFFFFF, 16'sd23039, 24'hFFFFFF, -16'sd23040,
                                         24'hFFFFFF, 16'sd11520), 1'b0);
        send_word(MODE_ZERO, pack_phasors(24'hFFFFFF, 16'd0, 24'hFFFFFF, 16'd0,
                                          24'hFFFFFF, 16'd0), 1'b0);
        send_word(MODE_UAB, pack_phasors(24'hFFFFFF, 16'sd5760, 24'hFFFFFF, 16'sd17280,
                                         24'd0, 16'd0), 1'b0);
        send_word(MODE_UCA, pack_phasors(24'd1, 16'h8000, 24'd0, 16'h7FFF,
                                         24'hFFFFFF, 16'h7FFF), 1'b0);
        send_word(MODE_NEG, pack_phasors(24'hFFFFFF, 16'h8000, 24'hFFFFFF, 16'h7FFF,
                                         24'hFFFFFF, 16'hFFFF), 1'b0);
        send_word(MODE_NEG, pack_phasors(24'hFFFFFF, 16'd0, 24'hFFFFFF, 16'sd7680,
                                         24'hFFFFFF, -16'sd7680), 1'b0);
        // zero vectors: all zero, equal phases in a difference, balanced set summed
        send_word(MODE_ZERO, '0, 1'b0);
        send_word(MODE_UBC, pack_phasors(24'd0, 16'd0, 24'd5000, 16'sd300,
                                         24'd5000, 16'sd300), 1'b0);
        send_word(MODE_UAB, pack_phasors(24'd77, -16'sd5761, 24'd77, -16'sd5761,
                                         24'd9, 16'd1), 1'b0);
        send_word(MODE_ZERO, pack_phasors(24'd25600, 16'd0, 24'd25600, -16'sd7680,
                                          24'd25600, 16'sd7680), 1'b0);
        send_word(MODE_UCA, pack_phasors(24'd1, -16'sd1, 24'd0, 16'd0,
                                         24'd1, 16'sd17279), 1'b0);

        // Random: bursts of balanced or near-balanced sets, the rest free-form.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            burst = $urandom_range(0, 9);
            mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            if (burst < 4) begin
                m = rand_mag();
                base = rand_ang();
                send_word(mode, pack_phasors(m, base,
                    m + 24'($urandom_range(0, 3)), base - 16'd7680 + 16'($urandom_range(0, 2)),
                    m, base + 16'd7680), steady_sink);
            end else begin
                send_word(mode, pack_phasors(rand_mag(), rand_ang(), rand_mag(), rand_ang(),
                                             rand_mag(), rand_ang()), steady_sink);
            end
        end
        i_s_tvalid = 1'b0;

        // Drain, then give the pipeline time to show any stray word.
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("sent %0d words (%0d with an invalid mode), checked %0d results",
                 words_sent, bad_mode_words, checked);
        $display("modes 0-7, magnitude and angle extremes, zero vectors, gaps and stalls");
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
